FILE: hdl/lcg_random_with_ball_sampling_assert.svh
// assertion macros for the lcg sampler
`ifndef LCG_RANDOM_WITH_BALL_SAMPLING_ASSERT_SVH
`define LCG_RANDOM_WITH_BALL_SAMPLING_ASSERT_SVH

// same-cycle implication
`define LCGB_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// next-cycle implication
`define LCGB_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

FILE: hdl/lcgball_pkg.sv
package lcgball_pkg;

    localparam int DRAW_BITS = 15;
    localparam int DRAW_LSB  = 16;
    localparam int CW        = DRAW_BITS + 2;
    localparam int SQW       = 2 * DRAW_BITS;
    localparam int AW        = SQW + 2;

    localparam logic [DRAW_BITS-1:0] DRAW_MAX = {DRAW_BITS{1'b1}};
    localparam logic [63:0] DRAW_MAX64 = 64'((64'd1 << DRAW_BITS) - 64'd1);
    localparam logic [AW-1:0] LIMIT = AW'(DRAW_MAX64 * DRAW_MAX64);

    localparam logic [31:0] LCG_MUL = 32'd214013;
    localparam logic [31:0] LCG_ADD = 32'd2531011;

    localparam logic [1:0] OP_RAW   = 2'd0;
    localparam logic [1:0] OP_RANGE = 2'd1;
    localparam logic [1:0] OP_BALL  = 2'd2;
    localparam logic [1:0] OP_DISC  = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] range_n;
    } t_in;

    typedef struct packed {
        logic [15:0]        value;
        logic signed [15:0] vec_x;
        logic signed [15:0] vec_y;
        logic signed [15:0] vec_z;
    } t_out;

    function automatic logic signed [15:0] sat16(input logic signed [CW-1:0] v);
        logic signed [31:0] w;
        logic signed [15:0] r;
        w = 32'(v);
        if (w > 32'sd32767) begin
            r = 16'sd32767;
        end else if (w < -32'sd32767) begin
            r = -16'sd32767;
        end else begin
            r = 16'(w);
        end
        return r;
    endfunction

endpackage

FILE: hdl/lcgball_mul.sv
module lcgball_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_p
);

    logic [31:0] w_prod;
    logic [31:0] r_p;

    // low word of the product only
    assign w_prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_p <= w_prod;
    end

    assign o_p = r_p;

endmodule

FILE: hdl/lcg_random_with_ball_sampling.sv
// path from transfer in to result valid: raw goes draw, output; ranged draw, range,
// quotient, output; ball, disc: draw, square, accumulate per axis, retried per try.
// one item at a time: the next transfer in is taken the cycle after the result is
// loaded; a full output register adds its wait.
// synchronous active-low reset clears the generator state to zero and
// empties the output register; no clearing pass.
`include "lcg_random_with_ball_sampling_assert.svh"

module lcg_random_with_ball_sampling (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_seed_we,
    input  logic [31:0]        i_seed_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lcgball_pkg::t_in   i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lcgball_pkg::t_out  o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAW,
        S_SQ,
        S_ACC,
        S_RANGE,
        S_RQ,
        S_OUT
    } t_fsm;

    t_fsm r_fsm;

    logic [31:0]                         r_state;
    logic [1:0]                          r_op;
    logic [15:0]                         r_n;
    logic [1:0]                          r_idx;
    logic [lcgball_pkg::AW-1:0]          r_acc;
    logic [15:0]                         r_value;
    logic signed [15:0]                  r_x;
    logic signed [15:0]                  r_y;
    logic signed [15:0]                  r_z;
    logic                                r_out_valid;
    lcgball_pkg::t_out                   r_out;

    logic [31:0]                         w_mul_a;
    logic [31:0]                         w_mul_b;
    logic [31:0]                         w_mul_q;
    logic [31:0]                         w_state_nxt;
    logic [lcgball_pkg::DRAW_BITS-1:0]   w_draw;
    logic [lcgball_pkg::DRAW_BITS-1:0]   w_draw_nxt;
    logic signed [lcgball_pkg::CW-1:0]   w_coord;
    logic signed [lcgball_pkg::CW-1:0]   w_coord_neg;
    logic [lcgball_pkg::DRAW_BITS-1:0]   w_mag;
    logic [lcgball_pkg::AW-1:0]          w_sum;
    logic [1:0]                          w_last;
    logic                                w_out_free;

    assign w_draw      = r_state[lcgball_pkg::DRAW_LSB +: lcgball_pkg::DRAW_BITS];
    assign w_state_nxt = w_mul_q + lcgball_pkg::LCG_ADD;
    assign w_draw_nxt  = w_state_nxt[lcgball_pkg::DRAW_LSB +: lcgball_pkg::DRAW_BITS];
    assign w_coord     = $signed({1'b0, w_draw, 1'b0})
                       - $signed(lcgball_pkg::CW'(lcgball_pkg::DRAW_MAX));
    assign w_coord_neg = -w_coord;
    assign w_mag       = w_coord[lcgball_pkg::CW-1]
                       ? lcgball_pkg::DRAW_BITS'(w_coord_neg)
                       : lcgball_pkg::DRAW_BITS'(w_coord);
    assign w_sum       = r_acc + lcgball_pkg::AW'(w_mul_q[lcgball_pkg::SQW-1:0]);
    assign w_last      = (r_op == lcgball_pkg::OP_BALL) ? 2'd2 : 2'd1;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // operand select for the shared multiplier
    always_comb begin
        w_mul_a = r_state;
        w_mul_b = lcgball_pkg::LCG_MUL;
        case (r_fsm)
            S_SQ: begin
                w_mul_a = 32'(w_mag);
                w_mul_b = 32'(w_mag);
            end
            S_RANGE: begin
                w_mul_a = 32'(w_draw);
                w_mul_b = 32'(r_n);
            end
            default: begin
                w_mul_a = r_state;
                w_mul_b = lcgball_pkg::LCG_MUL;
            end
        endcase
    end

    lcgball_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_state     <= '0;
            r_op        <= lcgball_pkg::OP_RAW;
            r_n         <= '0;
            r_idx       <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_seed_we) begin
                r_state <= i_seed_wdata;
            end else if (r_fsm == S_DRAW) begin
                r_state <= w_state_nxt;
            end
            if ((r_fsm == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_fsm)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_in_data.operation;
                        r_n     <= i_in_data.range_n;
                        r_idx   <= '0;
                        r_acc   <= '0;
                        r_value <= '0;
                        r_x     <= '0;
                        r_y     <= '0;
                        r_z     <= '0;
                        r_fsm   <= S_DRAW;
                    end
                end
                S_DRAW: begin
                    case (r_op)
                        lcgball_pkg::OP_RAW: begin
                            r_value <= 16'(w_draw_nxt);
                            r_fsm   <= S_OUT;
                        end
                        lcgball_pkg::OP_RANGE: begin
                            r_fsm <= S_RANGE;
                        end
                        default: begin
                            r_fsm <= S_SQ;
                        end
                    endcase
                end
                S_SQ: begin
                    if (r_idx == 2'd0) begin
                        r_x <= lcgball_pkg::sat16(w_coord);
                    end else if (r_idx == 2'd1 && r_op == lcgball_pkg::OP_DISC) begin
                        r_z <= lcgball_pkg::sat16(w_coord);
                    end else if (r_idx == 2'd1) begin
                        r_y <= lcgball_pkg::sat16(w_coord);
                    end else begin
                        r_z <= lcgball_pkg::sat16(w_coord);
                    end
                    r_fsm <= S_ACC;
                end
                S_ACC: begin
                    // next lcg step is issued from this state
                    if (r_idx != w_last) begin
                        r_acc <= w_sum;
                        r_idx <= r_idx + 2'd1;
                        r_fsm <= S_DRAW;
                    end else if (w_sum > lcgball_pkg::LIMIT) begin
                        r_acc <= '0;
                        r_idx <= '0;
                        r_fsm <= S_DRAW;
                    end else begin
                        r_acc <= w_sum;
                        r_fsm <= S_OUT;
                    end
                end
                S_RANGE: begin
                    r_fsm <= S_RQ;
                end
                S_RQ: begin
                    r_value <= 16'(w_mul_q >> lcgball_pkg::DRAW_BITS);
                    r_fsm   <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out.value <= r_value;
                        r_out.vec_x <= r_x;
                        r_out.vec_y <= r_y;
                        r_out.vec_z <= r_z;
                        r_fsm       <= S_IDLE;
                    end
                end
                default: begin
                    r_fsm <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_fsm == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `LCGB_ASSERT_NXT(a_busy_after_transfer, i_in_valid && o_in_ready, !o_in_ready)
    `LCGB_ASSERT_IMP(a_point_inside, (r_fsm == S_OUT) && (r_op == lcgball_pkg::OP_BALL || r_op == lcgball_pkg::OP_DISC), r_acc <= lcgball_pkg::LIMIT)
    `LCGB_ASSERT_IMP(a_value_excludes_point, o_out_valid && (o_out_data.value != 16'd0), (o_out_data.vec_x == 16'sd0) && (o_out_data.vec_y == 16'sd0) && (o_out_data.vec_z == 16'sd0))

endmodule

FILE: verif/tb_lcg_random_with_ball_sampling.sv
`timescale 1ns / 100ps

module tb_lcg_random_with_ball_sampling;

    localparam int DRAW_TOP    = (1 << lcgball_pkg::DRAW_BITS) - 1;
    localparam int PHASE_ITEMS = 220;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] n;
        logic        known;
        logic [15:0] value;
    } t_dir_row;

    typedef struct {
        bit                known;
        lcgball_pkg::t_out res;
    } t_answer;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_seed_we    = 1'b0;
    logic [31:0]       i_seed_wdata = '0;
    logic              i_in_valid   = 1'b0;
    logic              o_in_ready;
    lcgball_pkg::t_in  i_in_data    = '0;
    logic              o_out_valid;
    logic              i_out_ready  = 1'b0;
    lcgball_pkg::t_out o_out_data;

    logic        quiet        = 1'b0;
    logic [3:0]  hold_tag     = '0;
    logic [3:0]  hold_seen    = '0;
    int          hold_left    = 0;
    int          idle_cycles  = 0;

    logic [31:0]       gen_state    = '0;
    lcgball_pkg::t_out results_due[$];
    t_answer           fixed_answers[$];
    int                mismatches   = 0;
    int                n_in         = 0;
    int                n_out        = 0;
    int                n_seeds      = 0;
    int                op_seen[4]   = '{0, 0, 0, 0};

    // after reset the state is zero, so the first draw is bits 30..16 of 2531011
    t_dir_row directed_rows [20] = '{
        '{lcgball_pkg::OP_RAW,   16'h0000, 1'b1, 16'd38},
        '{lcgball_pkg::OP_RANGE, 16'h0000, 1'b1, 16'd0},
        '{lcgball_pkg::OP_RANGE, 16'hFFFF, 1'b0, 16'd0},
        '{lcgball_pkg::OP_RANGE, 16'h0001, 1'b1, 16'd0},
        '{lcgball_pkg::OP_RANGE, 16'h8000, 1'b0, 16'd0},
        '{lcgball_pkg::OP_RAW,   16'hFFFF, 1'b0, 16'd0},
        '{lcgball_pkg::OP_BALL,  16'h0000, 1'b0, 16'd0},
        '{lcgball_pkg::OP_DISC,  16'h0000, 1'b0, 16'd0},
        '{lcgball_pkg::OP_BALL,  16'hFFFF, 1'b0, 16'd0},
        '{lcgball_pkg::OP_DISC,  16'hFFFF, 1'b0, 16'd0},
        '{lcgball_pkg::OP_RANGE, 16'h7FFF, 1'b0, 16'd0},
        '{lcgball_pkg::OP_RANGE, 16'h5555, 1'b0, 16'd0},
        '{lcgball_pkg::OP_RANGE, 16'hAAAA, 1'b0, 16'd0},
        '{lcgball_pkg::OP_RAW,   16'h5555, 1'b0, 16'd0},
        '{lcgball_pkg::OP_BALL,  16'hAAAA, 1'b0, 16'd0},
        '{lcgball_pkg::OP_DISC,  16'h5555, 1'b0, 16'd0},
        '{lcgball_pkg::OP_RANGE, 16'h0002, 1'b0, 16'd0},
        '{lcgball_pkg::OP_RANGE, 16'h0000, 1'b1, 16'd0},
        '{lcgball_pkg::OP_BALL,  16'h0000, 1'b0, 16'd0},
        '{lcgball_pkg::OP_DISC,  16'hFFFF, 1'b0, 16'd0}
    };

    lcg_random_with_ball_sampling uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seed_we   (i_seed_we),
        .i_seed_wdata(i_seed_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [15:0] step_draw();
        gen_state = gen_state * lcgball_pkg::LCG_MUL + lcgball_pkg::LCG_ADD;
        return 16'((gen_state >> lcgball_pkg::DRAW_LSB) & 32'(DRAW_TOP));
    endfunction

    function automatic int step_coord();
        return 2 * int'(step_draw()) - DRAW_TOP;
    endfunction

    function automatic logic signed [15:0] clamp16(input int v);
        if (v > 32767) begin
            return 16'sd32767;
        end else if (v < -32767) begin
            return -16'sd32767;
        end
        return 16'(v);
    endfunction

    function automatic lcgball_pkg::t_out sample_point(input lcgball_pkg::t_in item);
        lcgball_pkg::t_out r;
        int     x;
        int     y;
        int     z;
        longint bound;
        r = '0;
        x = 0;
        y = 0;
        z = 0;
        bound = longint'(DRAW_TOP) * longint'(DRAW_TOP);
        case (item.operation)
            lcgball_pkg::OP_RAW: begin
                r.value = step_draw();
            end
            lcgball_pkg::OP_RANGE: begin
                r.value = 16'((64'(step_draw()) * 64'(item.range_n))
                              >> lcgball_pkg::DRAW_BITS);
            end
            lcgball_pkg::OP_BALL: begin
                do begin
                    x = step_coord();
                    y = step_coord();
                    z = step_coord();
                end while (longint'(x) * x + longint'(y) * y + longint'(z) * z > bound);
            end
            default: begin
                do begin
                    x = step_coord();
                    z = step_coord();
                end while (longint'(x) * x + longint'(z) * z > bound);
                y = 0;
            end
        endcase
        r.vec_x = clamp16(x);
        r.vec_y = clamp16(y);
        r.vec_z = clamp16(z);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result %0d %s: expected %h, got %h", n_out, name, want, got);
            end
        end
    endtask

    // predictor and scoreboard
    always @(posedge i_clk) begin : monitor
        lcgball_pkg::t_out want;
        t_answer           ans;
        if (!i_rst_n) begin
            gen_state = '0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result %h", o_out_data);
                    end
                end else begin
                    want = results_due.pop_front();
                    check_field("value", want.value, o_out_data.value);
                    check_field("vec_x", want.vec_x, o_out_data.vec_x);
                    check_field("vec_y", want.vec_y, o_out_data.vec_y);
                    check_field("vec_z", want.vec_z, o_out_data.vec_z);
                end
                n_out++;
            end
            if (i_seed_we) begin
                gen_state = i_seed_wdata;
            end
            if (i_in_valid && o_in_ready) begin
                want = sample_point(i_in_data);
                if (fixed_answers.size() != 0) begin
                    ans = fixed_answers.pop_front();
                    if (ans.known) begin
                        want = ans.res;
                    end
                end
                results_due.push_back(want);
                op_seen[i_in_data.operation]++;
                n_in++;
            end
        end
    end

    // output side: random back-pressure, quiet stretch, long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_seen   <= hold_tag;
        end else if (hold_tag != hold_seen) begin
            hold_seen   <= hold_tag;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= quiet || ($urandom_range(99) >= 29);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("no transfer for %0d cycles", STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [15:0] n,
                             input bit known, input logic [15:0] value);
        t_answer ans;
        ans.known     = known;
        ans.res       = '0;
        ans.res.value = value;
        while (!quiet && $urandom_range(99) < 29) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        fixed_answers.push_back(ans);
        i_in_valid          <= 1'b1;
        i_in_data.operation <= op;
        i_in_data.range_n   <= n;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        while (results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] v);
        i_seed_we    <= 1'b1;
        i_seed_wdata <= v;
        @(posedge i_clk);
        i_seed_we    <= 1'b0;
        n_seeds++;
    endtask

    function automatic logic [15:0] pick_range();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0001;
            3: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [31:0] seed_plan [5];
        seed_plan[0] = 32'hFFFF_FFFF;
        seed_plan[1] = 32'h0000_0000;
        seed_plan[2] = $urandom;
        seed_plan[3] = 32'h8000_0000;
        seed_plan[4] = $urandom;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].op, directed_rows[i].n,
                      directed_rows[i].known, directed_rows[i].value);
        end
        i_in_valid <= 1'b0;

        for (int p = 0; p < 5; p++) begin
            drain();
            write_seed(seed_plan[p]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 1 && k == 0) begin
                    quiet <= 1'b1;
                end
                if (p == 1 && k == 120) begin
                    quiet <= 1'b0;
                end
                if (p == 2 && k == 100) begin
                    hold_tag <= hold_tag + 4'd1;
                end
                send_item(2'($urandom_range(3)), pick_range(), 1'b0, 16'd0);
            end
            i_in_valid <= 1'b0;
        end

        drain();
        repeat (30) @(posedge i_clk);

        $display("%0d items over %0d seeds: raw %0d, ranged %0d, ball %0d, disc %0d",
                 n_in, n_seeds, op_seen[lcgball_pkg::OP_RAW], op_seen[lcgball_pkg::OP_RANGE],
                 op_seen[lcgball_pkg::OP_BALL], op_seen[lcgball_pkg::OP_DISC]);
        $display("%0d results checked, %0d mismatches", n_out, mismatches);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/lcgball_pkg.sv
hdl/lcgball_mul.sv
hdl/lcg_random_with_ball_sampling.sv
verif/tb_lcg_random_with_ball_sampling.sv
